// ----- rtl/sdph_pkg.sv -----
// Shared types and constants for the SMS-DELIVER header parser.
package sdph_pkg;

  // Widths of internal sums and of the kept byte count.
  localparam int SUM_W = 11;
  localparam int LEN_W = 10;

  localparam int QUEUE_DEPTH = 2;

  // First octet fields.
  localparam int   UDHI_BIT = 6;
  localparam logic [7:0] MTI_MASK = 8'h03;
  localparam logic [7:0] MTI_DELIVER = 8'h00;

  // Data coding scheme fields.
  localparam logic [7:0] DCS_CLASS_FLAG = 8'h10;
  localparam logic [7:0] DCS_ALPHA_MASK = 8'h0c;
  localparam logic [7:0] DCS_ALPHA_UCS2 = 8'h08;
  localparam logic [7:0] DCS_ALPHA_8BIT = 8'h04;
  localparam logic [3:0] DCS_GRP_GSM_A = 4'hc;
  localparam logic [3:0] DCS_GRP_GSM_B = 4'hd;
  localparam logic [3:0] DCS_GRP_UCS2 = 4'he;
  localparam logic [3:0] DCS_GRP_DATA = 4'hf;
  localparam logic [3:0] DCS_GRP_GENERAL_LAST = 4'h3;
  localparam logic [2:0] CLASS_NONE = 3'd4;

  // Concatenation information element identifiers and minimum lengths.
  localparam logic [7:0] IEI_CONCAT8 = 8'h00;
  localparam logic [7:0] IEI_CONCAT16 = 8'h08;
  localparam logic [7:0] CONCAT8_LEN = 8'd3;
  localparam logic [7:0] CONCAT16_LEN = 8'd4;
  localparam logic [7:0] ELEM_KEEP = 8'd4;

  // Fixed header octets outside the SMSC and sender digits, and offsets from the first octet.
  localparam logic [SUM_W-1:0] HDR_FIXED = 11'd14;
  localparam logic [SUM_W-1:0] OFS_TYPE = 11'd2;
  localparam logic [SUM_W-1:0] OFS_DCS = 11'd4;
  localparam logic [SUM_W-1:0] OFS_UDL = 11'd12;
  localparam logic [SUM_W-1:0] OFS_UD = 11'd13;
  localparam logic [8:0] TEXT_OFFSET_MAX = 9'd511;

  // Division by seven of values below 512: q = (x * 293) >> 11.
  localparam logic [8:0] SEPTET = 9'd7;
  localparam logic [8:0] RECIP7 = 9'd293;
  localparam int RECIP7_SHIFT = 11;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_SHORT       = 2'd1,
    ST_NOT_DELIVER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ENC_UNKNOWN = 2'd0,
    ENC_GSM7    = 2'd1,
    ENC_8BIT    = 2'd2,
    ENC_UCS2    = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    WALK_ID   = 2'd0,
    WALK_LEN  = 2'd1,
    WALK_DATA = 2'd2,
    WALK_DONE = 2'd3
  } walk_phase_t;

  // Everything the back end needs from one PDU.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       smsc;
    logic [7:0]       first;
    logic [7:0]       digits;
    logic [7:0]       addr_type;
    logic [7:0]       coding;
    logic [7:0]       udl;
    logic [7:0]       hdr_len;
    logic [31:0]      concat;
  } rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  coding_byte;
    logic [1:0]  encoding;
    logic [2:0]  class_code;
    logic [7:0]  sender_digit_count;
    logic [7:0]  sender_type_plan;
    logic [15:0] part_reference;
    logic [7:0]  part_total;
    logic [7:0]  part_sequence;
    logic [8:0]  text_offset;
    logic [7:0]  text_length;
    logic [2:0]  fill_bits;
  } res_t;

endpackage

// ----- rtl/sms_deliver_pdu_header_parser.sv -----
// Throughput: one byte per cycle while the queue has space; the front end takes the first
// byte of the next PDU while the previous summary is still in the queue, the back end or
// the result register. Each summary passes a two-entry queue and two back-end stages
// after the last beat of its PDU is accepted, one PDU per cycle while results are taken.
// Reset: synchronous rst clears the byte count, the header walk and all valid flags.
module sms_deliver_pdu_header_parser
  import sdph_pkg::*;
#(
  parameter int MAX_PDU_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pdu_valid,
  output logic        pdu_ready,
  input  logic [7:0]  pdu_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [7:0]  coding_byte,
  output logic [1:0]  encoding,
  output logic [2:0]  class_code,
  output logic [7:0]  sender_digit_count,
  output logic [7:0]  sender_type_plan,
  output logic [15:0] part_reference,
  output logic [7:0]  part_total,
  output logic [7:0]  part_sequence,
  output logic [8:0]  text_offset,
  output logic [7:0]  text_length,
  output logic [2:0]  fill_bits
);

  logic space;
  logic avail;
  logic push;
  logic pop;
  rec_t wr_rec;
  rec_t rd_rec;
  res_t res;

  sdph_front #(
    .MAX_PDU_BYTES(MAX_PDU_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pdu_valid(pdu_valid),
    .pdu_byte (pdu_byte),
    .last_byte(last_byte),
    .space    (space),
    .pdu_ready(pdu_ready),
    .push     (push),
    .rec      (wr_rec)
  );

  sdph_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(wr_rec),
    .pop    (pop),
    .space  (space),
    .avail  (avail),
    .rd_data(rd_rec)
  );

  sdph_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .rec      (rd_rec),
    .pop      (pop),
    .res_valid(result_valid),
    .res_ready(result_ready),
    .res      (res)
  );

  assign status             = res.status;
  assign coding_byte        = res.coding_byte;
  assign encoding           = res.encoding;
  assign class_code         = res.class_code;
  assign sender_digit_count = res.sender_digit_count;
  assign sender_type_plan   = res.sender_type_plan;
  assign part_reference     = res.part_reference;
  assign part_total         = res.part_total;
  assign part_sequence      = res.part_sequence;
  assign text_offset        = res.text_offset;
  assign text_length        = res.text_length;
  assign fill_bits          = res.fill_bits;

endmodule

// ----- rtl/sdph_front.sv -----
// Byte front end: locates header fields and walks the user data header.
module sdph_front
  import sdph_pkg::*;
#(
  parameter int MAX_PDU_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pdu_valid,
  input  logic [7:0] pdu_byte,
  input  logic       last_byte,
  input  logic       space,
  output logic       pdu_ready,
  output logic       push,
  output rec_t       rec
);

  localparam int POS_W = $clog2(MAX_PDU_BYTES + 1);

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       smsc, smsc_next;
  logic [7:0]       first, first_next;
  logic [7:0]       digits, digits_next;
  logic [7:0]       addr_type, addr_type_next;
  logic [7:0]       coding, coding_next;
  logic [7:0]       udl, udl_next;
  logic [7:0]       hdr_len, hdr_len_next;
  logic [7:0]       cursor, cursor_next;
  logic [7:0]       elem_id, elem_id_next;
  logic [7:0]       elem_len, elem_len_next;
  logic [31:0]      elem_bytes, elem_bytes_next;
  logic [31:0]      concat, concat_next;
  logic [SUM_W-1:0] walk_next, walk_next_next;
  walk_phase_t      phase, phase_next;

  logic             accept;
  logic             cap;
  logic             finish;
  logic             ok8, ok16;
  logic [SUM_W-1:0] p, ms, nn, uoff, r;
  logic [15:0]      f_ref;
  logic [7:0]       f_tot, f_seq;

  assign pdu_ready = space;
  assign accept    = pdu_valid && pdu_ready;
  assign push      = accept && last_byte;

  always_comb begin
    pos_next        = pos;
    smsc_next       = smsc;
    first_next      = first;
    digits_next     = digits;
    addr_type_next  = addr_type;
    coding_next     = coding;
    udl_next        = udl;
    hdr_len_next    = hdr_len;
    cursor_next     = cursor;
    elem_id_next    = elem_id;
    elem_len_next   = elem_len;
    elem_bytes_next = elem_bytes;
    concat_next     = concat;
    walk_next_next  = walk_next;
    phase_next      = phase;
    finish          = 1'b0;
    ok8             = 1'b0;
    ok16            = 1'b0;
    f_ref           = '0;
    f_tot           = '0;
    f_seq           = '0;

    cap  = pos < POS_W'(MAX_PDU_BYTES);
    p    = SUM_W'(pos);
    ms   = SUM_W'(smsc) + SUM_W'(1);
    nn   = SUM_W'((9'(digits) + 9'd1) >> 1);
    uoff = ms + OFS_UD + nn;
    r    = p - uoff;

    // Every later field position is at least one past the one that sets it,
    // so the registered values are the ones that locate this byte.
    if (cap) begin
      pos_next = pos + POS_W'(1);
      if (p == '0) smsc_next = pdu_byte;
      if (p == ms) first_next = pdu_byte;
      if (p == ms + SUM_W'(1)) digits_next = pdu_byte;
      if (p == ms + OFS_TYPE) addr_type_next = pdu_byte;
      if (p == ms + OFS_DCS + nn) coding_next = pdu_byte;
      if (p == ms + OFS_UDL + nn) udl_next = pdu_byte;

      if (first[UDHI_BIT] && p >= uoff) begin
        if (r == '0) begin
          hdr_len_next   = pdu_byte;
          walk_next_next = SUM_W'(1);
          phase_next     = WALK_ID;
        end else begin
          case (phase)
            WALK_ID: begin
              if (r == walk_next) begin
                if (r < SUM_W'(hdr_len) + SUM_W'(1)) begin
                  elem_id_next = pdu_byte;
                  phase_next   = WALK_LEN;
                end else begin
                  phase_next = WALK_DONE;
                end
              end
            end
            WALK_LEN: begin
              elem_len_next   = pdu_byte;
              cursor_next     = '0;
              elem_bytes_next = '0;
              phase_next      = WALK_DATA;
              finish          = (pdu_byte == 8'd0);
            end
            WALK_DATA: begin
              if (cursor < ELEM_KEEP) begin
                elem_bytes_next[{cursor[1:0], 3'b000} +: 8] =
                  elem_bytes[{cursor[1:0], 3'b000} +: 8] | pdu_byte;
              end
              cursor_next = cursor + 8'd1;
              finish      = (cursor_next >= elem_len);
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (finish) begin
      ok8  = (elem_id == IEI_CONCAT8) && (elem_len_next >= CONCAT8_LEN) &&
             (cursor_next >= CONCAT8_LEN);
      ok16 = (elem_id == IEI_CONCAT16) && (elem_len_next >= CONCAT16_LEN) &&
             (cursor_next >= CONCAT16_LEN);
      if (ok8) begin
        f_ref = {8'd0, elem_bytes_next[7:0]};
        f_tot = elem_bytes_next[15:8];
        f_seq = elem_bytes_next[23:16];
      end else begin
        f_ref = {elem_bytes_next[7:0], elem_bytes_next[15:8]};
        f_tot = elem_bytes_next[23:16];
        f_seq = elem_bytes_next[31:24];
      end
      // Entries with a zero or out-of-range part number are skipped.
      if ((ok8 || ok16) && f_seq != 8'd0 && f_seq <= f_tot) begin
        concat_next = {f_ref, f_tot, f_seq};
      end
      walk_next_next = r + SUM_W'(1);
      phase_next     = WALK_ID;
    end
  end

  always_comb begin
    rec.len       = LEN_W'(pos_next);
    rec.smsc      = smsc_next;
    rec.first     = first_next;
    rec.digits    = digits_next;
    rec.addr_type = addr_type_next;
    rec.coding    = coding_next;
    rec.udl       = udl_next;
    rec.hdr_len   = hdr_len_next;
    rec.concat    = concat_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos        <= '0;
      smsc       <= '0;
      first      <= '0;
      digits     <= '0;
      addr_type  <= '0;
      coding     <= '0;
      udl        <= '0;
      hdr_len    <= '0;
      cursor     <= '0;
      elem_id    <= '0;
      elem_len   <= '0;
      elem_bytes <= '0;
      concat     <= '0;
      walk_next  <= SUM_W'(1);
      phase      <= WALK_ID;
    end else if (accept) begin
      pos        <= pos_next;
      smsc       <= smsc_next;
      first      <= first_next;
      digits     <= digits_next;
      addr_type  <= addr_type_next;
      coding     <= coding_next;
      udl        <= udl_next;
      hdr_len    <= hdr_len_next;
      cursor     <= cursor_next;
      elem_id    <= elem_id_next;
      elem_len   <= elem_len_next;
      elem_bytes <= elem_bytes_next;
      concat     <= concat_next;
      walk_next  <= walk_next_next;
      phase      <= phase_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_PDU_BYTES))
    else $error("byte count ran past the PDU limit");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (pos == '0) && (concat == '0) && (phase == WALK_ID))
    else $error("front end not cleared after the last beat");
`endif

endmodule

// ----- rtl/sdph_fifo.sv -----
// Short queue of per-PDU records between the front and back ends.
module sdph_fifo
  import sdph_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wr_data,
  input  logic pop,
  output logic space,
  output logic avail,
  output rec_t rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  rec_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign space   = count != (PTR_W + 1)'(QUEUE_DEPTH);
  assign avail   = count != '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("record pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("record popped from an empty queue");
`endif

endmodule

// ----- rtl/sdph_back.sv -----
// Back end: length checks, coding map and text placement, then the result register.
module sdph_back
  import sdph_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic avail,
  input  rec_t rec,
  output logic pop,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       first;
    logic [7:0]       digits;
    logic [7:0]       addr_type;
    logic [7:0]       coding;
    logic [7:0]       udl;
    logic [8:0]       udhl;
    logic [6:0]       q7;
    enc_t             enc;
    logic [9:0]       base;
    logic [8:0]       need;
    logic [31:0]      concat;
  } stage_t;

  function automatic enc_t map_encoding(input logic [7:0] dcs);
    enc_t e;
    e = ENC_GSM7;
    if (dcs[7:4] <= DCS_GRP_GENERAL_LAST) begin
      if ((dcs & DCS_ALPHA_MASK) == DCS_ALPHA_UCS2) e = ENC_UCS2;
      else if ((dcs & DCS_ALPHA_MASK) == DCS_ALPHA_8BIT) e = ENC_8BIT;
    end else if (dcs[7:4] == DCS_GRP_GSM_A || dcs[7:4] == DCS_GRP_GSM_B) begin
      e = ENC_GSM7;
    end else if (dcs[7:4] == DCS_GRP_UCS2) begin
      e = ENC_UCS2;
    end else if (dcs[7:4] == DCS_GRP_DATA) begin
      e = ((dcs & DCS_ALPHA_8BIT) != 8'd0) ? ENC_8BIT : ENC_GSM7;
    end
    return e;
  endfunction

  stage_t s1, s1_next;
  logic   s1_valid;
  logic   s1_ready;
  logic   load_out;
  res_t   res_next;

  logic [8:0]  n9;
  logic [11:0] udl1, udl7;
  logic [17:0] prod7;

  logic [8:0]  sevenq;
  logic [2:0]  rem7;
  logic [2:0]  fill;
  logic [9:0]  sub;
  logic [9:0]  off10;
  logic [7:0]  tl;
  logic [SUM_W-1:0] total;
  logic        udhi;
  status_t     st;

  assign load_out = s1_valid && (!res_valid || res_ready);
  assign s1_ready = !s1_valid || load_out;
  assign pop      = avail && s1_ready;

  // First stage: coding map, minimum length and the divide by seven.
  always_comb begin
    n9    = (9'(rec.digits) + 9'd1) >> 1;
    udl1  = 12'(rec.udl) + 12'd1;
    udl7  = (udl1 << 3) - udl1;
    s1_next.len       = rec.len;
    s1_next.first     = rec.first;
    s1_next.digits    = rec.digits;
    s1_next.addr_type = rec.addr_type;
    s1_next.coding    = rec.coding;
    s1_next.udl       = rec.udl;
    s1_next.udhl      = 9'(rec.hdr_len) + 9'd1;
    prod7             = 18'(s1_next.udhl) * 18'(RECIP7);
    s1_next.q7        = prod7[RECIP7_SHIFT +: 7];
    s1_next.enc       = map_encoding(rec.coding);
    s1_next.base      = 10'(rec.smsc) + 10'(n9) + 10'(HDR_FIXED);
    s1_next.need      = (s1_next.enc == ENC_GSM7) ? udl7[11:3] : 9'(rec.udl);
    s1_next.concat    = rec.concat;
  end

  // Second stage: checks, header septet padding and text placement.
  always_comb begin
    udhi   = s1.first[UDHI_BIT];
    sevenq = (9'(s1.q7) << 3) - 9'(s1.q7);
    rem7   = 3'(s1.udhl - sevenq);
    fill   = (rem7 == 3'd0) ? 3'd0 : 3'(SEPTET) - rem7;
    if (s1.enc == ENC_GSM7) begin
      // Header bits plus padding, in septets: udhl + ceil(udhl / 7).
      sub = 10'(s1.udhl) + 10'(s1.q7) + 10'(rem7 != 3'd0);
    end else begin
      sub = 10'(s1.udhl);
    end
    if (!udhi) tl = s1.udl;
    else if (10'(s1.udl) > sub) tl = 8'(10'(s1.udl) - sub);
    else tl = 8'd0;
    off10 = s1.base + (udhi ? 10'(s1.udhl) : 10'd0);
    total = SUM_W'(s1.base) + SUM_W'(s1.need);

    if (SUM_W'(s1.len) < total) st = ST_SHORT;
    else if ((s1.first & MTI_MASK) != MTI_DELIVER) st = ST_NOT_DELIVER;
    else st = ST_OK;

    res_next = '0;
    res_next.status = st;
    if (st == ST_OK) begin
      res_next.coding_byte        = s1.coding;
      res_next.encoding           = s1.enc;
      res_next.class_code         = ((s1.coding & DCS_CLASS_FLAG) != 8'd0) ?
                                    {1'b0, s1.coding[1:0]} : CLASS_NONE;
      res_next.sender_digit_count = s1.digits;
      res_next.sender_type_plan   = s1.addr_type;
      if (udhi) begin
        res_next.part_reference = s1.concat[31:16];
        res_next.part_total     = s1.concat[15:8];
        res_next.part_sequence  = s1.concat[7:0];
      end
      res_next.text_offset = (off10 > 10'(TEXT_OFFSET_MAX)) ?
                             TEXT_OFFSET_MAX : off10[8:0];
      res_next.text_length = tl;
      res_next.fill_bits   = (udhi && s1.enc == ENC_GSM7) ? fill : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= avail;
      if (load_out) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1 <= s1_next;
    if (load_out) res <= res_next;
  end

`ifndef SYNTHESIS
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |->
      (res.coding_byte == 8'd0 && res.text_offset == 9'd0 &&
       res.part_total == 8'd0 && res.text_length == 8'd0))
    else $error("error result carries field data");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.fill_bits <= 3'd6 && res.class_code <= CLASS_NONE))
    else $error("fill or class out of range");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the SMS-DELIVER header parser.
`timescale 1ns / 1ps

module testbench
  import sdph_pkg::*;
();

  localparam int PDU_LIMIT = 256;

  typedef struct {
    bit [7:0] data;
    bit       last;
    bit       hold;
  } pdu_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        pdu_valid = 1'b0;
  logic        pdu_ready;
  logic [7:0]  pdu_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  coding_byte;
  logic [1:0]  encoding;
  logic [2:0]  class_code;
  logic [7:0]  sender_digit_count;
  logic [7:0]  sender_type_plan;
  logic [15:0] part_reference;
  logic [7:0]  part_total;
  logic [7:0]  part_sequence;
  logic [8:0]  text_offset;
  logic [7:0]  text_length;
  logic [2:0]  fill_bits;

  sms_deliver_pdu_header_parser #(.MAX_PDU_BYTES(PDU_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .pdu_valid(pdu_valid), .pdu_ready(pdu_ready), .pdu_byte(pdu_byte), .last_byte(last_byte),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .coding_byte(coding_byte), .encoding(encoding), .class_code(class_code),
    .sender_digit_count(sender_digit_count), .sender_type_plan(sender_type_plan),
    .part_reference(part_reference), .part_total(part_total), .part_sequence(part_sequence),
    .text_offset(text_offset), .text_length(text_length), .fill_bits(fill_bits)
  );

  // Stimulus and scoreboard storage.
  pdu_beat_t   pending_beats[$];
  bit [7:0]    pdu_build[$];
  bit [7:0]    ud_build[$];
  res_t        summaries_due[$];
  int unsigned pdus_queued = 0;
  int unsigned beats_accepted = 0;
  int unsigned pdus_predicted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_ok = 0, n_short = 0, n_not_deliver = 0, n_multipart = 0;

  // Parser state mirrored by the predictor.
  bit [8:0]    pos_cnt;
  bit [7:0]    smsc_len, first_oct, addr_digits, addr_type, dcs_oct, ud_len, udh_len;
  bit [7:0]    ie_cursor, ie_id, ie_len;
  bit [31:0]   ie_data, concat_word;
  walk_phase_t ie_phase;
  bit [8:0]    ie_next_start;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic clear_parser();
    pos_cnt = '0; smsc_len = '0; first_oct = '0; addr_digits = '0; addr_type = '0;
    dcs_oct = '0; ud_len = '0; udh_len = '0; ie_cursor = '0; ie_id = '0; ie_len = '0;
    ie_data = '0; concat_word = '0; ie_phase = WALK_ID; ie_next_start = 9'd1;
  endtask

  function automatic enc_t dcs_encoding(input bit [7:0] dcs);
    enc_t e;
    case (dcs[7:4])
      4'h0, 4'h1, 4'h2, 4'h3: begin
        if ((dcs & DCS_ALPHA_MASK) == DCS_ALPHA_UCS2) e = ENC_UCS2;
        else if ((dcs & DCS_ALPHA_MASK) == DCS_ALPHA_8BIT) e = ENC_8BIT;
        else e = ENC_GSM7;
      end
      DCS_GRP_UCS2: e = ENC_UCS2;
      DCS_GRP_DATA: e = dcs[2] ? ENC_8BIT : ENC_GSM7;
      default: e = ENC_GSM7;
    endcase
    return e;
  endfunction

  task automatic close_element(input int unsigned r);
    bit [15:0] ref_v;
    bit [7:0]  tot;
    bit [7:0]  seq;
    bit        usable;
    usable = 1'b0; ref_v = '0; tot = '0; seq = '0;
    if (ie_id == IEI_CONCAT8 && ie_len >= CONCAT8_LEN && ie_cursor >= CONCAT8_LEN) begin
      ref_v = {8'h00, ie_data[7:0]}; tot = ie_data[15:8]; seq = ie_data[23:16];
      usable = 1'b1;
    end else if (ie_id == IEI_CONCAT16 && ie_len >= CONCAT16_LEN &&
                 ie_cursor >= CONCAT16_LEN) begin
      ref_v = {ie_data[7:0], ie_data[15:8]}; tot = ie_data[23:16]; seq = ie_data[31:24];
      usable = 1'b1;
    end
    if (usable && seq != 0 && seq <= tot) concat_word = {ref_v, tot, seq};
    ie_next_start = 9'(r + 1);
    ie_phase = WALK_ID;
  endtask

  // Walks the information elements; r is the index within the user data.
  task automatic walk_udh(input int unsigned r, input bit [7:0] b);
    if (r == 0) begin
      udh_len = b;
      ie_next_start = 9'd1;
      ie_phase = WALK_ID;
    end else begin
      case (ie_phase)
        WALK_ID: begin
          if (r == ie_next_start) begin
            if (r < udh_len + 1) begin
              ie_id = b;
              ie_phase = WALK_LEN;
            end else begin
              ie_phase = WALK_DONE;
            end
          end
        end
        WALK_LEN: begin
          ie_len = b;
          ie_cursor = '0;
          ie_data = '0;
          ie_phase = WALK_DATA;
          if (ie_len == 0) close_element(r);
        end
        WALK_DATA: begin
          if (ie_cursor < ELEM_KEEP) ie_data |= 32'(b) << (8 * ie_cursor);
          ie_cursor++;
          if (ie_cursor >= ie_len) close_element(r);
        end
        default: ;
      endcase
    end
  endtask

  task automatic parse_pdu_byte(input bit [7:0] b, input bit is_last, output bit emitted);
    int unsigned ms, n, uoff, len, udl, need, udhl, sub, off, tl, fill;
    enc_t        enc;
    status_t     st;
    res_t        s;
    emitted = 1'b0;
    if (pos_cnt < PDU_LIMIT) begin
      if (pos_cnt == 0) smsc_len = b;
      ms = 1 + smsc_len;
      if (pos_cnt == ms) first_oct = b;
      if (pos_cnt == ms + 1) addr_digits = b;
      if (pos_cnt == ms + 2) addr_type = b;
      n = (addr_digits + 1) >> 1;
      if (pos_cnt == ms + 4 + n) dcs_oct = b;
      if (pos_cnt == ms + 12 + n) ud_len = b;
      uoff = ms + 13 + n;
      if (first_oct[UDHI_BIT] && pos_cnt >= uoff) walk_udh(pos_cnt - uoff, b);
      pos_cnt++;
    end
    if (is_last) begin
      s = '0;
      len = pos_cnt;
      n = (addr_digits + 1) >> 1;
      udl = ud_len;
      enc = dcs_encoding(dcs_oct);
      need = (enc == ENC_GSM7) ? (7 * (udl + 1)) / 8 : udl;
      if (len < smsc_len + 14 || len < smsc_len + n + 14 || len < smsc_len + n + need + 14)
        st = ST_SHORT;
      else if ((first_oct & MTI_MASK) != MTI_DELIVER)
        st = ST_NOT_DELIVER;
      else
        st = ST_OK;
      s.status = st;
      if (st == ST_OK) begin
        off = smsc_len + n + 14;
        tl = udl;
        fill = 0;
        if (first_oct[UDHI_BIT]) begin
          udhl = udh_len + 1;
          off += udhl;
          if (enc == ENC_GSM7) begin
            // Text restarts on a septet boundary after the header.
            fill = (7 - udhl % 7) % 7;
            sub = (udhl * 8 + fill) / 7;
          end else begin
            sub = udhl;
          end
          tl = (tl > sub) ? tl - sub : 0;
          s.part_reference = concat_word[31:16];
          s.part_total = concat_word[15:8];
          s.part_sequence = concat_word[7:0];
        end
        if (off > TEXT_OFFSET_MAX) off = TEXT_OFFSET_MAX;
        s.coding_byte = dcs_oct;
        s.encoding = enc;
        s.class_code = dcs_oct[4] ? {1'b0, dcs_oct[1:0]} : CLASS_NONE;
        s.sender_digit_count = addr_digits;
        s.sender_type_plan = addr_type;
        s.text_offset = 9'(off);
        s.text_length = 8'(tl);
        s.fill_bits = 3'(fill);
        n_ok++;
        if (s.part_total != 0) n_multipart++;
      end else if (st == ST_SHORT) begin
        n_short++;
      end else begin
        n_not_deliver++;
      end
      summaries_due.push_back(s);
      clear_parser();
      emitted = 1'b1;
    end
  endtask

  // Stimulus builders.
  task automatic queue_pdu(input bit hold);
    pdu_beat_t beat;
    foreach (pdu_build[i]) begin
      beat.data = pdu_build[i];
      beat.last = (i == pdu_build.size() - 1);
      beat.hold = hold && (i == 0);
      pending_beats.push_back(beat);
    end
    pdus_queued++;
  endtask

  task automatic make_udh(input int n_ie, input int first_kind, input int hl_trim);
    int       kind, tot, seq, ie_n, hl;
    bit [7:0] id;
    ud_build.delete();
    ud_build.push_back(8'h00);
    for (int k = 0; k < n_ie; k++) begin
      kind = (k == 0 && first_kind >= 0) ? first_kind : int'($urandom_range(0, 5));
      tot = $urandom_range(1, 6);
      seq = $urandom_range(1, tot);
      case (kind)
        0: begin
          ud_build.push_back(IEI_CONCAT8); ud_build.push_back(CONCAT8_LEN);
          ud_build.push_back(8'($urandom)); ud_build.push_back(8'(tot));
          ud_build.push_back(8'(seq));
        end
        1: begin
          ud_build.push_back(IEI_CONCAT16); ud_build.push_back(CONCAT16_LEN);
          ud_build.push_back(8'($urandom)); ud_build.push_back(8'($urandom));
          ud_build.push_back(8'(tot)); ud_build.push_back(8'(seq));
        end
        2: begin
          // Concatenation element too short to carry its fields.
          id = $urandom_range(0, 1) ? IEI_CONCAT8 : IEI_CONCAT16;
          ie_n = (id == IEI_CONCAT8) ? 2 : 3;
          ud_build.push_back(id); ud_build.push_back(8'(ie_n));
          repeat (ie_n) ud_build.push_back(8'($urandom));
        end
        3: begin
          ie_n = $urandom_range(0, 5);
          ud_build.push_back(8'($urandom)); ud_build.push_back(8'(ie_n));
          repeat (ie_n) ud_build.push_back(8'($urandom));
        end
        4: begin
          ud_build.push_back(IEI_CONCAT8); ud_build.push_back(8'd5);
          ud_build.push_back(8'($urandom)); ud_build.push_back(8'(tot));
          ud_build.push_back(8'(seq));
          ud_build.push_back(8'($urandom)); ud_build.push_back(8'($urandom));
        end
        default: begin
          // Sequence number of zero or past the total must be ignored.
          seq = $urandom_range(0, 1) ? 0 : int'($urandom_range(tot + 1, 255));
          id = $urandom_range(0, 1) ? IEI_CONCAT8 : IEI_CONCAT16;
          ud_build.push_back(id);
          ud_build.push_back((id == IEI_CONCAT8) ? CONCAT8_LEN : CONCAT16_LEN);
          ud_build.push_back(8'($urandom));
          if (id == IEI_CONCAT16) ud_build.push_back(8'($urandom));
          ud_build.push_back(8'(tot)); ud_build.push_back(8'(seq));
        end
      endcase
    end
    hl = ud_build.size() - 1 - hl_trim;
    if (hl < 0) hl = 0;
    ud_build[0] = 8'(hl);
  endtask

  task automatic make_deliver(input int smsc_n, input bit [7:0] first, input bit [7:0] digits,
                              input bit [7:0] dcs, input int n_ie, input int ie_kind,
                              input int hl_trim, input int text_n, input int udl_adj,
                              input int cut, input bit hold);
    int udl;
    pdu_build.delete();
    pdu_build.push_back(8'(smsc_n));
    repeat (smsc_n) pdu_build.push_back(8'($urandom));
    pdu_build.push_back(first);
    pdu_build.push_back(digits);
    pdu_build.push_back(8'($urandom));
    repeat ((int'(digits) + 1) / 2) pdu_build.push_back(8'($urandom));
    pdu_build.push_back(8'($urandom));
    pdu_build.push_back(dcs);
    repeat (7) pdu_build.push_back(8'($urandom));
    if (first[UDHI_BIT]) make_udh(n_ie, ie_kind, hl_trim);
    else ud_build.delete();
    repeat (text_n) ud_build.push_back(8'($urandom));
    udl = (dcs_encoding(dcs) == ENC_GSM7) ? ud_build.size() * 8 / 7 : ud_build.size();
    udl += udl_adj;
    if (udl < 0) udl = 0;
    if (udl > 255) udl = 255;
    pdu_build.push_back(8'(udl));
    foreach (ud_build[i]) pdu_build.push_back(ud_build[i]);
    repeat (cut) if (pdu_build.size() > 1) void'(pdu_build.pop_back());
    queue_pdu(hold);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;

  always @(posedge clk) begin : drive_pdu
    pdu_beat_t   beat;
    bit          made;
    bit          valid_n;
    int unsigned owed;
    if (rst) begin
      pdu_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 1;
    end else begin
      made = 1'b0;
      if (pdu_valid && pdu_ready) begin
        parse_pdu_byte(pdu_byte, last_byte, made);
        beats_accepted <= beats_accepted + 1;
        if (made) pdus_predicted <= pdus_predicted + 1;
      end
      owed = pdus_predicted + made;
      if (!pdu_valid || pdu_ready) begin
        valid_n = 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_beats.size() != 0 &&
                     (!pending_beats[0].hold || results_seen == owed)) begin
          beat = pending_beats.pop_front();
          pdu_byte <= beat.data;
          last_byte <= beat.last;
          valid_n = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 16);
            gap_left <= $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        pdu_valid <= valid_n;
      end
    end
  end

  // Receiver: alternates between always ready, coin flips and mostly stalled.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(4, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= $urandom_range(0, 1);
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic check_field(input int unsigned idx, input string what,
                             input int unsigned got, input int unsigned want);
    if (got != want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Summary %0d: %s is 0x%0h, expected 0x%0h", idx, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_summary
    res_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen <= results_seen + 1;
      if (summaries_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Summary %0d arrived with none pending", results_seen);
      end else begin
        want = summaries_due.pop_front();
        check_field(results_seen, "status", status, want.status);
        check_field(results_seen, "coding_byte", coding_byte, want.coding_byte);
        check_field(results_seen, "encoding", encoding, want.encoding);
        check_field(results_seen, "class_code", class_code, want.class_code);
        check_field(results_seen, "sender_digit_count", sender_digit_count,
                    want.sender_digit_count);
        check_field(results_seen, "sender_type_plan", sender_type_plan, want.sender_type_plan);
        check_field(results_seen, "part_reference", part_reference, want.part_reference);
        check_field(results_seen, "part_total", part_total, want.part_total);
        check_field(results_seen, "part_sequence", part_sequence, want.part_sequence);
        check_field(results_seen, "text_offset", text_offset, want.text_offset);
        check_field(results_seen, "text_length", text_length, want.text_length);
        check_field(results_seen, "fill_bits", fill_bits, want.fill_bits);
      end
    end
  end

  initial begin
    int unsigned total_beats;
    int unsigned rnd_pdus;
    int          pick;
    bit [7:0]    first;
    clear_parser();

    // Directed PDUs.
    pdu_build.delete(); pdu_build.push_back(8'h00); queue_pdu(1'b0);
    pdu_build.delete(); pdu_build.push_back(8'hff); queue_pdu(1'b0);
    make_deliver(0, 8'h00, 8'h00, 8'h00, 0, -1, 0, 0, 0, 0, 1'b0);
    // Header flag set but the PDU stops before the header length byte.
    make_deliver(0, 8'h40, 8'h00, 8'h00, 0, -1, 0, 0, -1, 1, 1'b0);
    make_deliver(1, 8'h44, 8'd11, 8'h00, 1, 0, 0, 5, 0, 0, 1'b0);
    make_deliver(2, 8'h64, 8'd4, 8'h18, 2, 1, 0, 6, 0, 0, 1'b0);
    make_deliver(0, 8'h40, 8'd3, 8'hf4, 1, 5, 0, 3, 0, 0, 1'b0);
    // Last element runs past the declared header end.
    make_deliver(0, 8'h40, 8'd2, 8'h11, 2, 0, 2, 4, 0, 0, 1'b0);
    make_deliver(0, 8'h40, 8'd1, 8'hc2, 1, 2, 0, 0, -4, 0, 1'b0);
    make_deliver(0, 8'h01, 8'd6, 8'he3, 0, -1, 0, 2, 0, 0, 1'b0);
    make_deliver(0, 8'h43, 8'd6, 8'h00, 1, 0, 0, 2, 0, 0, 1'b0);
    make_deliver(3, 8'h04, 8'd9, 8'h00, 0, -1, 0, 8, 0, 3, 1'b0);
    make_deliver(0, 8'h00, 8'hff, 8'hff, 0, -1, 0, 10, 0, 0, 1'b0);
    make_deliver(0, 8'h00, 8'd10, 8'h04, 0, -1, 0, 280, 0, 0, 1'b0);

    // Random PDUs: mostly well formed with random content, some noise and breakage.
    rnd_pdus = 0;
    while (pending_beats.size() < 1150 || pdus_queued < 40) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        pdu_build.delete();
        repeat ($urandom_range(1, 40)) pdu_build.push_back(8'($urandom));
        queue_pdu(rnd_pdus % 16 == 0);
      end else if (pick < 13) begin
        make_deliver($urandom_range(0, 255), 8'($urandom), 8'($urandom), 8'($urandom),
                     $urandom_range(0, 3), -1, 0, $urandom_range(0, 30), 0, 0,
                     rnd_pdus % 16 == 0);
      end else begin
        first = 8'($urandom);
        if ($urandom_range(0, 9) != 0) first[1:0] = 2'b00;
        make_deliver($urandom_range(0, 8), first, 8'($urandom_range(0, 20)), 8'($urandom),
                     $urandom_range(0, 3), -1,
                     ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 3)) : 0,
                     $urandom_range(0, 20),
                     ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 16)) - 12 : 0,
                     ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 5)) : 0,
                     rnd_pdus % 16 == 0);
      end
      rnd_pdus++;
    end
    total_beats = pending_beats.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (beats_accepted != total_beats || results_seen != pdus_predicted) @(posedge clk);
    repeat (8) @(posedge clk);

    if (summaries_due.size() != 0) begin
      $display("%0d summaries never arrived", summaries_due.size());
      mismatch_count++;
    end
    $display("Sent %0d PDUs in %0d beats; summaries: %0d ok (%0d multipart), %0d too short,",
             pdus_queued, total_beats, n_ok, n_multipart, n_short);
    $display("%0d not SMS-DELIVER; %0d mismatches", n_not_deliver, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sdph_pkg.sv
rtl/sdph_front.sv
rtl/sdph_fifo.sv
rtl/sdph_back.sv
rtl/sms_deliver_pdu_header_parser.sv
tb/testbench.sv
